// File: src/xxh_pkg.sv
// Package for the streaming 64-bit hash block: primes, widths, command struct.
// Used by every module in src; depends on nothing.
package xxh_pkg;
  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 4;
  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

  // datapath operations; each product step holds until the multiplier is done
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,     // latch input word, open message if needed
    OpRoundA,   // lane acc += w*P2 (lane index in cmd)
    OpRoundB,   // lane = rotl(acc,31)*P1
    OpMergeInit,// h = rotl sum or lanes[2]+P5
    OpMergeA,   // t = rotl(lane*P2,31)
    OpMergeB,   // t = t*P1
    OpMergeC,   // h = (h^t)*P1
    OpAddP4,    // h += P4
    OpAddLen,   // h += total_length
    OpWordA,    // t = rotl(word*P2,31)
    OpWordB,    // t = t*P1
    OpWordC,    // h = rotl(h^t,27)*P1 + P4
    OpTailA,    // t = low part of tail * prime
    OpTailB,    // h = rotl(h^t,r)*prime
    OpAvalA     // avalanche step (sub step in cmd)
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic       is_last;
    logic       short_err;
    logic       mul_done;
    logic       stripe_done;
    logic       long_msg;
    logic [1:0] words_held;
    logic [3:0] tail_n;
  } dp_stat_t;

  function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] r);
    rotl = (v << r) | (v >> (7'd64 - {1'b0, r}));
  endfunction
endpackage

// File: src/xxh_stream_if.sv
// Valid/ready channel interface carrying one word of payload.
// Depends on nothing; payload type is a parameter.
interface xxh_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/xxh_datapath.sv
// Datapath: lanes, stripe buffer, length, hash accumulator and a multiplier built on 32x32 partial products.
// Depends on xxh_pkg; driven by xxh_ctrl.
module xxh_datapath import xxh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] seed_i,
  input  logic [63:0] word_i,
  input  logic [3:0]  count_i,
  input  logic        last_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  output logic [63:0] hash_o
);
  logic [63:0] lanes_q [4];
  logic [63:0] buf_q [3];
  logic [1:0]  held_q;
  logic [63:0] len_q;
  logic        long_q, open_q;
  logic [63:0] w_q, h_q, t_q, res_q;
  logic [3:0]  n_q;
  logic        last_q, err_q;

  logic [3:0]  n_sat;
  logic [63:0] w_mask, len_next;
  logic [63:0] mul_a, mul_b, prod;
  logic [63:0] cur_lane, cur_word;

  logic [1:0]  mul_cnt_q;
  logic [63:0] mul_acc_q;
  logic        mul_op, mul_done;
  logic [31:0] part_a, part_b;
  logic [63:0] part_p;

  assign n_sat = (count_i > 4'd8) ? 4'd8 : count_i;
  always_comb begin
    w_mask = word_i;
    if (n_sat < 4'd8) w_mask = word_i & ((64'd1 << {n_sat[2:0], 3'b000}) - 64'd1);
  end

  assign cur_lane = lanes_q[cmd_i.sel[1:0]];
  assign cur_word = (cmd_i.sel[1:0] == 2'd3) ? w_q : buf_q[cmd_i.sel[1:0]];
  assign len_next = (open_q ? len_q : 64'd0) + {60'd0, n_sat};

  // select multiplier operands for this step
  always_comb begin
    mul_a = t_q;
    mul_b = P1;
    case (cmd_i.op)
      OpRoundA: begin mul_a = cur_word; mul_b = P2; end
      OpRoundB: begin mul_a = rotl(t_q, 6'd31); mul_b = P1; end
      OpMergeA: begin mul_a = cur_lane; mul_b = P2; end
      OpMergeB: begin mul_a = t_q; mul_b = P1; end
      OpMergeC: begin mul_a = h_q ^ t_q; mul_b = P1; end
      OpWordA:  begin mul_a = buf_q[cmd_i.sel[1:0]]; mul_b = P2; end
      OpWordB:  begin mul_a = t_q; mul_b = P1; end
      OpWordC:  begin mul_a = rotl(h_q ^ t_q, 6'd27); mul_b = P1; end
      OpTailA: begin
        if (cmd_i.sel[0]) begin mul_a = {32'd0, w_q[31:0]}; mul_b = P1; end
        else begin mul_a = {56'd0, w_q[7:0]}; mul_b = P5; end
      end
      OpTailB: begin
        if (cmd_i.sel[0]) begin mul_a = rotl(h_q ^ t_q, 6'd23); mul_b = P2; end
        else begin mul_a = rotl(h_q ^ t_q, 6'd11); mul_b = P1; end
      end
      OpAvalA: begin
        if (cmd_i.sel[0]) begin mul_a = h_q ^ (h_q >> 33); mul_b = P2; end
        else begin mul_a = h_q ^ (h_q >> 29); mul_b = P3; end
      end
      default: ;
    endcase
  end

  // flag the steps that need a product
  always_comb begin
    case (cmd_i.op)
      OpRoundA, OpRoundB, OpMergeA, OpMergeB, OpMergeC, OpWordA, OpWordB, OpWordC,
      OpTailA, OpTailB, OpAvalA: mul_op = 1'b1;
      default: mul_op = 1'b0;
    endcase
  end

  // low 64 bits of the product from three 32x32 partial products, one per cycle
  always_comb begin
    case (mul_cnt_q)
      2'd0: begin part_a = mul_a[31:0]; part_b = mul_b[31:0]; end
      2'd1: begin part_a = mul_a[31:0]; part_b = mul_b[63:32]; end
      default: begin part_a = mul_a[63:32]; part_b = mul_b[31:0]; end
    endcase
  end
  assign part_p   = {32'd0, part_a} * {32'd0, part_b};
  assign mul_done = mul_op && (mul_cnt_q == 2'd3);
  assign prod     = mul_acc_q;

  // advance the multiplier step count while a product step is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= '0;
    end else if (mul_op && mul_cnt_q != 2'd3) begin
      mul_cnt_q <= mul_cnt_q + 2'd1;
    end else begin
      mul_cnt_q <= '0;
    end
  end

  // accumulate partial products
  always_ff @(posedge clk_i) begin
    case (mul_cnt_q)
      2'd0: mul_acc_q <= part_p;
      2'd1, 2'd2: mul_acc_q <= mul_acc_q + {part_p[31:0], 32'd0};
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      len_q  <= '0;
      long_q <= 1'b0;
      open_q <= 1'b0;
      last_q <= 1'b0;
      err_q  <= 1'b0;
      n_q    <= '0;
    end else begin
      case (cmd_i.op)
        OpLoad: begin
          last_q <= last_i;
          err_q  <= !last_i && (n_sat < 4'd8);
          n_q    <= (n_sat == 4'd8) ? 4'd0 : n_sat;
          if (!last_i && n_sat < 4'd8) begin
            open_q <= 1'b0;
          end else begin
            len_q  <= len_next;
            long_q <= (open_q && long_q) || (len_next >= 64'd32);
            open_q <= !last_i;
            if (n_sat == 4'd8) begin
              if (!open_q) held_q <= 2'd1;
              else if (held_q != 2'd3) held_q <= held_q + 2'd1;
            end else if (!open_q) begin
              held_q <= '0;
            end
          end
        end
        OpRoundB: if (mul_done && cmd_i.sel[1:0] == 2'd3) held_q <= '0;
        OpTailB: if (mul_done) n_q <= cmd_i.sel[0] ? n_q - 4'd4 : n_q - 4'd1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpLoad: begin
        w_q <= w_mask;
        if (!open_q) begin
          lanes_q[0] <= seed_i + P1 + P2;
          lanes_q[1] <= seed_i + P2;
          lanes_q[2] <= seed_i;
          lanes_q[3] <= seed_i - P1;
        end
        if (n_sat == 4'd8) begin
          if (!open_q) buf_q[0] <= w_mask;
          else if (held_q != 2'd3) buf_q[held_q] <= w_mask;
        end
      end
      OpRoundA: if (mul_done) t_q <= cur_lane + prod;
      OpRoundB: if (mul_done) lanes_q[cmd_i.sel[1:0]] <= prod;
      OpMergeInit: h_q <= long_q ?
        rotl(lanes_q[0], 6'd1) + rotl(lanes_q[1], 6'd7) +
        rotl(lanes_q[2], 6'd12) + rotl(lanes_q[3], 6'd18) : lanes_q[2] + P5;
      OpMergeA, OpWordA: if (mul_done) t_q <= rotl(prod, 6'd31);
      OpMergeB, OpWordB, OpTailA: if (mul_done) t_q <= prod;
      OpMergeC: if (mul_done) h_q <= prod;
      OpWordC: if (mul_done) h_q <= prod + P4;
      OpAddP4: h_q <= h_q + P4;
      OpAddLen: begin
        h_q <= h_q + len_q;
        if (last_q && n_q == 4'd0) w_q <= 64'd0;
      end
      OpTailB: if (mul_done) begin
        h_q <= cmd_i.sel[0] ? prod + P3 : prod;
        w_q <= cmd_i.sel[0] ? (w_q >> 32) : (w_q >> 8);
      end
      // last avalanche step lands in the result register
      OpAvalA: if (mul_done) begin
        if (cmd_i.sel[0]) h_q <= prod;
        else res_q <= prod ^ (prod >> 32);
      end
      default: ;
    endcase
  end

  // MergeA/WordA already rotated, so MergeB/WordB just multiply by P1
  assign stat_o.is_last     = last_q;
  assign stat_o.short_err   = err_q;
  assign stat_o.mul_done    = mul_done;
  assign stat_o.stripe_done = open_q && (held_q == 2'd3) && (n_sat == 4'd8);
  assign stat_o.long_msg    = long_q;
  assign stat_o.words_held  = held_q;
  assign stat_o.tail_n      = n_q;
  assign hash_o = res_q;
endmodule

// File: src/xxh_ctrl.sv
// Controller: sequences stripe rounds, merge, buffered-word and tail folding and avalanche.
// Depends on xxh_pkg; drives xxh_datapath.
module xxh_ctrl import xxh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic     out_err_o,
  input  dp_stat_t stat_i,
  input  logic     stripe_i,
  output dp_cmd_t  cmd_o
);
  localparam logic [3:0] SIdle = 4'd0, SDecide = 4'd1, SRndA = 4'd2, SRndB = 4'd3,
    SMInit = 4'd4, SMA = 4'd5, SMB = 4'd6, SMC = 4'd7, SMP4 = 4'd8, SLen = 4'd9,
    SWA = 4'd10, SWB = 4'd11, SWC = 4'd12, STA = 4'd13, STB = 4'd14, SAval = 4'd15;

  logic [3:0] state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       stripe_q, stripe_d;
  logic       ov_q, ov_d, oe_q, oe_d;
  logic       tail4;

  assign tail4 = stat_i.tail_n >= 4'd4;
  assign in_ready_o = (state_q == SIdle);
  assign out_valid_o = ov_q;
  assign out_err_o = oe_q;

  always_comb begin
    state_d = state_q; idx_d = idx_q; stripe_d = stripe_q; ov_d = ov_q; oe_d = oe_q;
    cmd_o.op = OpNone; cmd_o.sel = idx_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      SIdle: if (in_valid_i && in_ready_o) begin
        cmd_o.op = OpLoad; stripe_d = stripe_i; state_d = SDecide;
      end
      SDecide: begin
        idx_d = 3'd0;
        // hold the error word until the result register is free
        if (stat_i.short_err) begin
          if (!ov_q || out_ready_i) begin
            ov_d = 1'b1; oe_d = 1'b1; state_d = SIdle;
          end
        end
        else if (stripe_q) state_d = SRndA;
        else if (stat_i.is_last) state_d = SMInit;
        else state_d = SIdle;
      end
      SRndA: begin cmd_o.op = OpRoundA; if (stat_i.mul_done) state_d = SRndB; end
      SRndB: begin
        cmd_o.op = OpRoundB;
        if (stat_i.mul_done) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd3) begin
            idx_d = 3'd0; state_d = stat_i.is_last ? SMInit : SIdle;
          end else state_d = SRndA;
        end
      end
      SMInit: begin
        cmd_o.op = OpMergeInit; idx_d = 3'd0;
        state_d = stat_i.long_msg ? SMA : SLen;
      end
      SMA: begin cmd_o.op = OpMergeA; if (stat_i.mul_done) state_d = SMB; end
      SMB: begin cmd_o.op = OpMergeB; if (stat_i.mul_done) state_d = SMC; end
      SMC: begin cmd_o.op = OpMergeC; if (stat_i.mul_done) state_d = SMP4; end
      SMP4: begin
        cmd_o.op = OpAddP4; idx_d = idx_q + 3'd1;
        state_d = (idx_q == 3'd3) ? SLen : SMA;
      end
      SLen: begin
        cmd_o.op = OpAddLen; idx_d = 3'd0;
        state_d = (stat_i.words_held != 2'd0) ? SWA : STA;
      end
      SWA: begin cmd_o.op = OpWordA; if (stat_i.mul_done) state_d = SWB; end
      SWB: begin cmd_o.op = OpWordB; if (stat_i.mul_done) state_d = SWC; end
      // after WordC take the next buffered word or go on to the tail
      SWC: begin
        cmd_o.op = OpWordC;
        if (stat_i.mul_done) begin
          idx_d = idx_q + 3'd1;
          state_d = (idx_q + 3'd1 == {1'b0, stat_i.words_held}) ? STA : SWA;
        end
      end
      STA: begin
        cmd_o.sel = {2'b00, tail4};
        if (stat_i.tail_n == 4'd0) begin state_d = SAval; idx_d = 3'd1; end
        else begin
          cmd_o.op = OpTailA;
          if (stat_i.mul_done) state_d = STB;
        end
      end
      STB: begin
        cmd_o.op = OpTailB; cmd_o.sel = {2'b00, tail4};
        if (stat_i.mul_done) state_d = STA;
      end
      SAval: begin
        cmd_o.sel = idx_q;
        if (idx_q == 3'd1) begin
          cmd_o.op = OpAvalA;
          if (stat_i.mul_done) idx_d = 3'd0;
        end else if (!ov_q || out_ready_i) begin
          // last step writes the result register, so start it only once that is free
          cmd_o.op = OpAvalA;
          if (stat_i.mul_done) begin ov_d = 1'b1; oe_d = 1'b0; state_d = SIdle; end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; idx_q <= '0; stripe_q <= 1'b0; ov_q <= 1'b0; oe_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; stripe_q <= stripe_d; ov_q <= ov_d; oe_q <= oe_d;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == SDecide) else $error("load not followed");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_err_o)) else $error("result changed");
`endif
endmodule

// File: src/xxh64_streaming_hash.sv
// Top level of the streaming 64-bit hash; joins controller and datapath.
// Depends on xxh_pkg, xxh_stream_if, xxh_ctrl, xxh_datapath.
//
// Usage: input words arrive on in_if (data_word, byte_count, last), little-endian,
// one valid/ready handshake per word. Only the last word may hold fewer than
// 8 bytes; a short non-last word ends the message and returns a result with
// error set and hash_value zero. The seed register is written through
// seed_we_i/seed_wdata_i and is used at each message start; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// Each 64-bit product is built from three partial products on one shared 32x32
// multiplier. A word is accepted only while the controller is idle; a non-last word
// that completes a 32-byte stripe runs two products per lane before the next is taken.
// After a last word the result follows the stripe rounds, the lane merge of a long
// message, a fold per buffered word and per tail chunk, and the avalanche.
// The result waits in an output register until taken on out_if; words are still
// accepted meanwhile, and the next result is held back while that register is full.
// Reset clears the seed, lengths and handshake state.
module xxh64_streaming_hash import xxh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [63:0] seed_wdata_i,
  xxh_stream_if.sink  in_if,
  xxh_stream_if.source out_if
);
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [63:0] seed_q, hash;
  logic        err;

  // hold the seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= '0;
    else if (seed_we_i) seed_q <= seed_wdata_i;
  end

  xxh_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .in_ready_o (in_if.ready),
    .out_valid_o (out_if.valid), .out_ready_i (out_if.ready),
    .out_err_o (err), .stat_i (stat),
    .stripe_i (stat.stripe_done),
    .cmd_o (cmd)
  );

  xxh_datapath u_dp (
    .clk_i, .rst_ni, .seed_i (seed_q),
    .word_i (in_if.payload.data_word), .count_i (in_if.payload.byte_count),
    .last_i (in_if.payload.last), .cmd_i (cmd), .stat_o (stat), .hash_o (hash)
  );

  assign out_if.payload.hash_value = err ? 64'd0 : hash;
  assign out_if.payload.error = err;
endmodule

// File: tb/sv/xxh_tb_pkg.sv
`timescale 1ns / 100ps
// Word formats for the input and result channels of the streaming hash bench.
// Depends on nothing; used by the checker and the bench top.
package xxh_tb_pkg;
  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
  } msg_word_t;

  typedef struct packed {
    logic [63:0] hash_value;
    logic        error;
  } digest_t;
endpackage

// File: tb/sv/xxh64_streaming_hash_checker.sv
`timescale 1ns / 100ps
// Watches both channels and the seed port, predicts each digest and compares.
// Depends on xxh_pkg for the primes and on xxh_tb_pkg for the word formats.
module xxh64_streaming_hash_checker import xxh_pkg::*; import xxh_tb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [63:0] seed_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  msg_word_t   in_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  digest_t     out_word_i,
  output int          fail_count_o,
  output int          digests_due_o
);
  logic [63:0] seed_q;
  logic [63:0] lane_q [4];
  logic [63:0] held_word_q [3];
  int          held_n_q;
  logic [63:0] msg_len_q;
  logic        long_q;
  logic        open_q;
  digest_t     digests_due_q [$];

  function automatic logic [63:0] rot_left(input logic [63:0] v, input int r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] lane_round(input logic [63:0] acc, input logic [63:0] w);
    logic [63:0] a;
    a = acc + w * P2;
    return rot_left(a, 31) * P1;
  endfunction

  // Fold the held state and the tail bytes into the final digest
  function automatic logic [63:0] digest_of(input logic [63:0] tail, input int n);
    logic [63:0] h;
    logic [63:0] t;
    int          k;
    t = tail;
    k = n;
    if (long_q) begin
      h = rot_left(lane_q[0], 1) + rot_left(lane_q[1], 7) + rot_left(lane_q[2], 12)
          + rot_left(lane_q[3], 18);
      for (int i = 0; i < 4; i++) begin
        h = h ^ lane_round(64'd0, lane_q[i]);
        h = h * P1 + P4;
      end
    end else begin
      h = lane_q[2] + P5;
    end
    h = h + msg_len_q;
    for (int i = 0; i < held_n_q; i++) begin
      h = h ^ lane_round(64'd0, held_word_q[i]);
      h = rot_left(h, 27) * P1 + P4;
    end
    if (k >= 4) begin
      h = h ^ ({32'd0, t[31:0]} * P1);
      h = rot_left(h, 23) * P2 + P3;
      t = t >> 32;
      k = k - 4;
    end
    while (k != 0) begin
      h = h ^ ({56'd0, t[7:0]} * P5);
      h = rot_left(h, 11) * P1;
      t = t >> 8;
      k--;
    end
    h = h ^ (h >> 33);
    h = h * P2;
    h = h ^ (h >> 29);
    h = h * P3;
    h = h ^ (h >> 32);
    return h;
  endfunction

  // Advance the hash state by one accepted word; queue a digest where one is due
  task automatic absorb_word(input msg_word_t item);
    logic [63:0] w;
    int          n;
    digest_t     d;
    w = item.data_word;
    n = (item.byte_count > 4'd8) ? 8 : int'(item.byte_count);
    if (n < 8) w = w & ((64'd1 << (8 * n)) - 64'd1);
    if (!open_q) begin
      lane_q[0] = seed_q + P1 + P2;
      lane_q[1] = seed_q + P2;
      lane_q[2] = seed_q;
      lane_q[3] = seed_q - P1;
      held_n_q  = 0;
      msg_len_q = '0;
      long_q    = 1'b0;
      open_q    = 1'b1;
    end
    if (!item.last && n < 8) begin
      open_q = 1'b0;
      d.hash_value = '0;
      d.error = 1'b1;
      digests_due_q.push_back(d);
      return;
    end
    msg_len_q = msg_len_q + 64'(n);
    if (msg_len_q >= 64'd32) long_q = 1'b1;
    if (n == 8) begin
      if (held_n_q == 3) begin
        for (int i = 0; i < 3; i++) lane_q[i] = lane_round(lane_q[i], held_word_q[i]);
        lane_q[3] = lane_round(lane_q[3], w);
        held_n_q = 0;
      end else begin
        held_word_q[held_n_q] = w;
        held_n_q++;
      end
      if (!item.last) return;
      n = 0;
      w = '0;
    end
    d.hash_value = digest_of(w, n);
    d.error = 1'b0;
    open_q = 1'b0;
    digests_due_q.push_back(d);
  endtask

  // Track the seed, predict on input words, compare on result words
  always @(posedge clk_i or negedge rst_ni) begin
    digest_t want;
    if (!rst_ni) begin
      seed_q = '0;
      held_n_q = 0;
      msg_len_q = '0;
      long_q = 1'b0;
      open_q = 1'b0;
      for (int i = 0; i < 4; i++) lane_q[i] = '0;
      digests_due_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (digests_due_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result word hash=%h error=%b", $realtime,
                     out_word_i.hash_value, out_word_i.error);
        end else begin
          want = digests_due_q.pop_front();
          if (want.hash_value !== out_word_i.hash_value || want.error !== out_word_i.error) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: hash exp %h got %h, error exp %b got %b", $realtime,
                       want.hash_value, out_word_i.hash_value, want.error, out_word_i.error);
          end
        end
      end
      if (in_valid_i && in_ready_i) absorb_word(in_word_i);
      if (seed_we_i) seed_q = seed_wdata_i;
    end
    digests_due_o = digests_due_q.size();
  end

  final begin
  end
endmodule

// File: tb/sv/xxh64_streaming_hash_test.sv
`timescale 1ns / 100ps
// Bench top for the streaming hash: clock, reset, seed writes and message stimulus.
// Depends on xxh_pkg, xxh_tb_pkg, xxh_stream_if, the checker and the block.
module xxh64_streaming_hash_test;
  import xxh_tb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        seed_we = 1'b0;
  logic [63:0] seed_wdata = '0;
  logic        calm = 1'b0;
  int          fail_count;
  int          digests_due;
  int          words_sent;

  xxh_stream_if #(.payload_t(msg_word_t)) in_if ();
  xxh_stream_if #(.payload_t(digest_t))   out_if ();

  xxh64_streaming_hash i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (seed_we),
    .seed_wdata_i(seed_wdata),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  xxh64_streaming_hash_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we),
    .seed_wdata_i (seed_wdata),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_word_i    (in_if.payload),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_word_i   (out_if.payload),
    .fail_count_o (fail_count),
    .digests_due_o(digests_due)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
  end

  // Stall the result side at random, except in calm stretches
  always @(negedge clk_i) begin
    out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
  end

  // Send one word; entered and left at a falling edge
  task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic fin);
    while (!calm && $urandom_range(99) < 26) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= '{data_word: w, byte_count: cnt, last: fin};
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    @(negedge clk_i);
    words_sent++;
  endtask

  // Drain every digest, let the block settle, then write the seed
  task automatic write_seed(input logic [63:0] s);
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (digests_due != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    seed_we <= 1'b1;
    seed_wdata <= s;
    @(negedge clk_i);
    seed_we <= 1'b0;
  endtask

  function automatic logic [63:0] pick_data();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One message of n full words and a closing word; may break early with a short word
  task automatic send_message(input int n, input bit broken);
    int cut;
    cut = broken ? $urandom_range(n) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == cut) begin
        send_word(pick_data(), 4'($urandom_range(7)), 1'b0);
        return;
      end
      send_word(pick_data(), 4'd8, 1'b0);
    end
    send_word(pick_data(), ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
              : 4'($urandom_range(8)), 1'b1);
  endtask

  initial begin
    int n;
    words_sent = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty and short closings, saturated count, errors, long messages
    calm = 1'b1;
    send_word('1, 4'd0, 1'b1);
    for (int c = 1; c <= 8; c++) send_word('1, 4'(c), 1'b1);
    send_word('1, 4'd15, 1'b1);
    send_word('0, 4'd3, 1'b0);
    send_word('1, 4'd8, 1'b0);
    send_word('1, 4'd0, 1'b0);
    for (int i = 0; i < 4; i++) send_word(64'h0123456789ABCDEF, 4'd8, 1'b0);
    send_word('0, 4'd8, 1'b1);
    for (int i = 0; i < 7; i++) send_word('1, 4'd8, 1'b0);
    send_word(64'hA5A5A5A55A5A5A5A, 4'd5, 1'b1);
    calm = 1'b0;

    // Random messages under several seeds, extremes among them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_seed('1);
        1: write_seed({$urandom, $urandom});
        2: write_seed('0);
        default: write_seed(64'h8000000000000001);
      endcase
      calm = (phase == 2);
      while (words_sent < 30 + 300 * (phase + 1)) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(40, 20) : $urandom_range(12);
        send_message(n, $urandom_range(19) == 0);
      end
    end
    calm = 1'b0;

    in_if.valid <= 1'b0;
    while (digests_due != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// File: xxh64_streaming_hash.f
src/xxh_pkg.sv
src/xxh_stream_if.sv
src/xxh_datapath.sv
src/xxh_ctrl.sv
src/xxh64_streaming_hash.sv
tb/sv/xxh_tb_pkg.sv
tb/sv/xxh64_streaming_hash_checker.sv
tb/sv/xxh64_streaming_hash_test.sv
